/* sv/kctt_pkg.sv */
// Shared types and constants for the keyed chunk tally table.
// Used by the cell, the top level and the checker; depends on nothing.
`default_nettype none

package kctt_pkg;

  localparam int unsigned KCTT_DEPTH_DEFAULT = 256;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned LEN_W   = 31;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned USED_W  = 9;

  typedef struct packed {
    logic [KEY_W-1:0] chunk_key;
    logic [LEN_W-1:0] chunk_length;
  } chunk_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]  entry_index;
    logic [CNT_W-1:0]  key_count;
    logic [CNT_W-1:0]  key_total_length;
    logic [USED_W-1:0] entries_in_use;
    logic              table_full;
  } chunk_res_t;

  // Lookup token handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic             valid;
    logic             found;
    logic             is_new;
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] total;
  } kctt_tok_t;

endpackage

`default_nettype wire

/* sv/kctt_cell.sv */
// One table entry of the keyed chunk tally chain: key, count and length total.
// Compares the passing token, updates or appends, and forwards it. Uses kctt_pkg.
`default_nettype none

module kctt_cell import kctt_pkg::*; #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned USE_W    = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [USE_W-1:0] used_i,
  input  kctt_tok_t        tok_i,
  output kctt_tok_t        tok_o
);

  localparam logic [USE_W-1:0] MyIdx   = USE_W'(CELL_IDX);
  localparam logic [IDX_W-1:0] MyIdxRp = IDX_W'(CELL_IDX % 256);

  logic [KEY_W-1:0] key_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] total_q, total_d;
  logic             wr_en;

  logic             in_use;
  logic             hit;
  logic             append;
  logic [CNT_W:0]   count_sum;
  logic [CNT_W:0]   total_sum;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] total_inc;
  kctt_tok_t        tok_d, tok_q;

  assign in_use = (MyIdx < used_i);
  assign hit    = tok_i.valid && !tok_i.found && in_use && (key_q == tok_i.key);
  assign append = tok_i.valid && !tok_i.found && (MyIdx == used_i);

  assign count_sum = {1'b0, count_q} + (CNT_W+1)'(1);
  assign total_sum = {1'b0, total_q} + {2'b00, tok_i.len};
  // Both sums saturate at all ones on carry out.
  assign count_inc = count_sum[CNT_W] ? '1 : count_sum[CNT_W-1:0];
  assign total_inc = total_sum[CNT_W] ? '1 : total_sum[CNT_W-1:0];

  always_comb begin
    count_d = count_q;
    total_d = total_q;
    wr_en   = 1'b0;
    tok_d   = tok_i;
    if (hit) begin
      count_d      = count_inc;
      total_d      = total_inc;
      wr_en        = 1'b1;
      tok_d.found  = 1'b1;
      tok_d.idx    = MyIdxRp;
      tok_d.count  = count_inc;
      tok_d.total  = total_inc;
    end else if (append) begin
      count_d      = CNT_W'(1);
      total_d      = {1'b0, tok_i.len};
      wr_en        = 1'b1;
      tok_d.found  = 1'b1;
      tok_d.is_new = 1'b1;
      tok_d.idx    = MyIdxRp;
      tok_d.count  = CNT_W'(1);
      tok_d.total  = {1'b0, tok_i.len};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      count_q <= count_d;
      total_q <= total_d;
    end
    if (append) begin
      key_q <= tok_i.key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

/* sv/keyed_chunk_tally_table_core.sv */
// Top level of the keyed chunk tally table: a chain of kctt_cell entries,
// the entry counter, busy control and the result register. Uses kctt_pkg.
//
//   port   dir  payload      transfer
//   start  in   req_i        start high while busy low
//   done_o out  res_o        one-cycle strobe, always taken
//
// An item enters cell 0 at the transfer and moves one cell per cycle; the
// result strobe is registered from the last cell's output and busy falls
// with it, so the next transfer can come at the edge that takes the result:
// a new item is taken only once the last one is through the whole cell chain.
// Reset clears the entry count, so no clearing pass is needed. The receiver
// cannot stall the block.
`default_nettype none

module keyed_chunk_tally_table_core import kctt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = KCTT_DEPTH_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  chunk_req_t req_i,
  output logic       done_o,
  output chunk_res_t res_o
);

  localparam int unsigned UseW = $clog2(TABLE_DEPTH + 1);

  kctt_tok_t       tok [TABLE_DEPTH+1];
  kctt_tok_t       tok_last;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [UseW-1:0] used_q, used_d;
  chunk_res_t      res_q, res_d;

  logic [UseW-1:0]        used_next;
  logic [UseW+USED_W-1:0] used_ext;
  logic                   accept;

  assign accept = start && !busy_q;

  always_comb begin
    tok[0]        = '0;
    tok[0].valid  = accept;
    tok[0].key    = req_i.chunk_key;
    tok[0].len    = req_i.chunk_length;
  end

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    kctt_cell #(
      .CELL_IDX(k),
      .USE_W   (UseW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .used_i (used_q),
      .tok_i  (tok[k]),
      .tok_o  (tok[k+1])
    );
  end

  assign tok_last  = tok[TABLE_DEPTH];
  assign used_next = used_q + UseW'(tok_last.is_new);
  assign used_ext  = {{USED_W{1'b0}}, used_next};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    used_d = used_q;
    res_d  = res_q;
    if (accept) begin
      busy_d = 1'b1;
    end
    if (tok_last.valid) begin
      busy_d = 1'b0;
      done_d = 1'b1;
      used_d = used_next;
      res_d.entries_in_use = used_ext[USED_W-1:0];
      if (tok_last.found) begin
        res_d.entry_index      = tok_last.idx;
        res_d.key_count        = tok_last.count;
        res_d.key_total_length = tok_last.total;
        res_d.table_full       = 1'b0;
      end else begin
        // Unknown key with every entry taken: dropped.
        res_d.entry_index      = '0;
        res_d.key_count        = '0;
        res_d.key_total_length = '0;
        res_d.table_full       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      used_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy   = busy_q;
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

/* sv/kctt_checker.sv */
// Port-level checks for keyed_chunk_tally_table_core, attached by bind.
// Uses kctt_pkg for the result type.
`default_nettype none

module kctt_checker import kctt_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input chunk_res_t res_o
);

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy did not rise after a transfer");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done strobe longer than one cycle");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

  a_busy_ends_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy fell without a result");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.table_full |->
      res_o.key_count == '0 && res_o.key_total_length == '0 &&
      res_o.entry_index == '0)
    else $error("dropped key reported nonzero fields");

endmodule

bind keyed_chunk_tally_table_core kctt_checker u_kctt_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .res_o  (res_o)
);

`default_nettype wire

/* test/tb.sv */
// Testbench for keyed_chunk_tally_table_core: a directed table, then random chunk records
// checked against a behavioral tally of keys, counts and saturating totals.
// Depends on kctt_pkg and the core RTL only.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kctt_pkg::*;

  localparam int unsigned DEPTH = KCTT_DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS = 800;
  localparam int QUIET_TAIL = 60;

  typedef struct packed {
    chunk_req_t req;
    logic       typed;
    chunk_res_t res;
  } stim_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic       done_o;
  chunk_req_t req_i;
  chunk_res_t res_o;

  // Behavioral copy of the tally table.
  logic [KEY_W-1:0] seen_key   [DEPTH];
  logic [CNT_W-1:0] seen_count [DEPTH];
  logic [CNT_W-1:0] seen_total [DEPTH];
  int unsigned      seen_used;

  chunk_res_t tally_expect_q[$];
  stim_row_t  dir_rows[$];
  int         mismatches;

  keyed_chunk_tally_table_core #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .res_o (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [CNT_W-1:0] sat_sum(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? '1 : s[CNT_W-1:0];
  endfunction

  // Looks the key up in first-seen order, updates the table and returns the result.
  function automatic chunk_res_t tally_update(input chunk_req_t r);
    chunk_res_t res;
    int         hit;
    res = '0;
    hit = -1;
    for (int i = 0; i < int'(seen_used); i++) begin
      if (hit < 0 && seen_key[i] == r.chunk_key) hit = i;
    end
    if (hit >= 0) begin
      seen_count[hit] = sat_sum(seen_count[hit], CNT_W'(1));
      seen_total[hit] = sat_sum(seen_total[hit], {1'b0, r.chunk_length});
    end else if (seen_used < DEPTH) begin
      hit = int'(seen_used);
      seen_key[hit]   = r.chunk_key;
      seen_count[hit] = CNT_W'(1);
      seen_total[hit] = {1'b0, r.chunk_length};
      seen_used++;
    end
    res.entries_in_use = USED_W'(seen_used);
    if (hit >= 0) begin
      res.entry_index      = IDX_W'(hit);
      res.key_count        = seen_count[hit];
      res.key_total_length = seen_total[hit];
    end else begin
      res.table_full = 1'b1;
    end
    return res;
  endfunction

  function automatic void add_row(input logic [KEY_W-1:0] key, input logic [LEN_W-1:0] len,
                                  input logic typed, input logic [IDX_W-1:0] idx,
                                  input logic [CNT_W-1:0] cnt, input logic [CNT_W-1:0] tot,
                                  input logic [USED_W-1:0] used);
    stim_row_t row;
    row.req.chunk_key         = key;
    row.req.chunk_length      = len;
    row.typed                 = typed;
    row.res.entry_index       = idx;
    row.res.key_count         = cnt;
    row.res.key_total_length  = tot;
    row.res.entries_in_use    = used;
    row.res.table_full        = 1'b0;
    dir_rows.push_back(row);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // One chunk record: optional idle burst once the core is free, then hold start
  // until the transfer happens.
  task automatic send_chunk(input chunk_req_t r, input logic typed,
                            input chunk_res_t typed_res, input bit idle);
    int         burst;
    chunk_res_t predicted;
    if (idle) begin
      @(negedge clk_i) start <= 1'b0;
      do @(posedge clk_i); while (busy);
      burst = $urandom_range(1, 11);
      repeat (burst) @(negedge clk_i);
    end
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    predicted = tally_update(r);
    tally_expect_q.push_back(typed ? typed_res : predicted);
  endtask

  always @(posedge clk_i) begin
    chunk_res_t want;
    if (rst_ni && done_o) begin
      if (tally_expect_q.size() == 0) begin
        $display("%0t ns: result with none expected, got %h", $time, res_o);
        mismatches++;
      end else begin
        want = tally_expect_q.pop_front();
        check_field("entry_index", 32'(want.entry_index), 32'(res_o.entry_index));
        check_field("key_count", want.key_count, res_o.key_count);
        check_field("key_total_length", want.key_total_length, res_o.key_total_length);
        check_field("entries_in_use", 32'(want.entries_in_use), 32'(res_o.entries_in_use));
        check_field("table_full", 32'(want.table_full), 32'(res_o.table_full));
      end
    end
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    chunk_req_t r;
    chunk_res_t no_res;
    int         pick;
    bit         idle;

    rst_ni     = 1'b0;
    start      = 1'b0;
    req_i      = '0;
    no_res     = '0;
    mismatches = 0;
    seen_used  = 0;

    // Extremes of both fields, then the total saturating on repeated maximum lengths.
    // A count cannot saturate within any feasible run, it needs 2**32 chunks.
    add_row(32'h0000_0000, 31'h0000_0000, 1'b1, 8'd0, 32'd1, 32'h0000_0000, 9'd1);
    add_row(32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 8'd1, 32'd1, 32'h7FFF_FFFF, 9'd2);
    add_row(32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 8'd1, 32'd2, 32'hFFFF_FFFE, 9'd2);
    add_row(32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 8'd1, 32'd3, 32'hFFFF_FFFF, 9'd2);
    add_row(32'hFFFF_FFFF, 31'h0000_0000, 1'b1, 8'd1, 32'd4, 32'hFFFF_FFFF, 9'd2);
    add_row(32'h0000_0000, 31'h7FFF_FFFF, 1'b1, 8'd0, 32'd2, 32'h7FFF_FFFF, 9'd2);
    add_row(32'h0000_0000, 31'h0000_0001, 1'b1, 8'd0, 32'd3, 32'h8000_0000, 9'd2);
    add_row(32'h8000_0000, 31'h4000_0000, 1'b1, 8'd2, 32'd1, 32'h4000_0000, 9'd3);
    add_row(32'h0000_0001, 31'h0000_0001, 1'b1, 8'd3, 32'd1, 32'h0000_0001, 9'd4);
    add_row(32'h5555_5555, 31'h2AAA_AAAA, 1'b0, '0, '0, '0, '0);
    add_row(32'hAAAA_AAAA, 31'h5555_5555, 1'b0, '0, '0, '0, '0);
    add_row(32'h7FFF_FFFF, 31'h7FFF_FFFE, 1'b0, '0, '0, '0, '0);
    add_row(32'hFFFF_FFFE, 31'h0000_0000, 1'b0, '0, '0, '0, '0);
    add_row(32'h0000_0001, 31'h7FFF_FFFF, 1'b0, '0, '0, '0, '0);
    add_row(32'h8000_0000, 31'h7FFF_FFFF, 1'b0, '0, '0, '0, '0);
    add_row(32'h8000_0000, 31'h4000_0000, 1'b0, '0, '0, '0, '0);
    add_row(32'h5555_5555, 31'h5555_5555, 1'b0, '0, '0, '0, '0);

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      send_chunk(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res,
                 $urandom_range(0, 2) == 0);
    end

    // Half the records bring a new key until the table fills, so the later part of
    // the run mixes hits on stored keys with new keys that are dropped as table full.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (seen_used == 0 || $urandom_range(0, 99) < 50) begin
        r.chunk_key = $urandom;
      end else begin
        r.chunk_key = seen_key[$urandom_range(0, seen_used - 1)];
      end
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        r.chunk_length = LEN_W'($urandom_range(0, 4095));
      end else if (pick < 8) begin
        r.chunk_length = LEN_W'($urandom);
      end else begin
        r.chunk_length = LEN_W'($urandom_range(32'h7FFF_0000, 32'h7FFF_FFFF));
      end
      idle = (i < RANDOM_ITEMS - QUIET_TAIL) && (i % 100 < 70) &&
             ($urandom_range(0, 2) == 0);
      send_chunk(r, 1'b0, no_res, idle);
    end

    @(negedge clk_i) start <= 1'b0;
    while (tally_expect_q.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 16) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
sv/kctt_pkg.sv
sv/kctt_cell.sv
sv/keyed_chunk_tally_table_core.sv
sv/kctt_checker.sv
test/tb.sv
